FILE: rtl/bfa_pkg.sv
// Package for the bond force accumulator: opcodes, widths, result kinds.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bfa_pkg;
	localparam int unsigned PointsDefault = 4096;
	localparam int unsigned CoordW = 32;
	localparam int unsigned SumW = 64;
	localparam int unsigned IdxW = 12;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_BOND = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	localparam logic KIND_BOND = 1'b0;
	localparam logic KIND_SUMS = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/bfa_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bfa_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

FILE: rtl/bfa_alu.sv
// Shared iterative unit: 128/64 restoring divide or 128-bit integer square root,
// one bit per cycle. Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none
module bfa_alu (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         go,
	input  wire logic         is_sqrt,
	input  wire logic [127:0] num,
	input  wire logic [63:0]  den,
	output logic              done,
	output logic [63:0]       res
);
	logic [7:0]   cnt_q;
	logic         busy_q;
	logic         sqrt_q;
	logic [127:0] n_q;
	logic [63:0]  d_q;
	logic [65:0]  rem_q;
	logic [63:0]  q_q;
	logic [129:0] rs_q;
	logic [65:0]  rem_sh;
	logic [65:0]  rem_sub;
	logic [129:0] sq_rem;
	logic [129:0] sq_trial;

	assign rem_sh   = {rem_q[64:0], n_q[127]};
	assign rem_sub  = rem_sh - {2'b00, d_q};
	assign sq_rem   = {rs_q[127:0], n_q[127:126]};
	assign sq_trial = sq_rem - {64'd0, q_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				sqrt_q <= is_sqrt;
				n_q    <= num;
				d_q    <= den;
				rem_q  <= '0;
				rs_q   <= '0;
				q_q    <= '0;
				cnt_q  <= is_sqrt ? 8'd64 : 8'd128;
			end else if (busy_q) begin
				if (sqrt_q) begin
					n_q <= {n_q[125:0], 2'b00};
					if (!sq_trial[129]) begin
						rs_q <= sq_trial;
						q_q  <= {q_q[62:0], 1'b1};
					end else begin
						rs_q <= sq_rem;
						q_q  <= {q_q[62:0], 1'b0};
					end
				end else begin
					n_q <= {n_q[126:0], 1'b0};
					if (!rem_sub[65]) begin
						rem_q <= rem_sub;
						q_q   <= {q_q[62:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						q_q   <= {q_q[62:0], 1'b0};
					end
				end
				cnt_q <= cnt_q - 8'd1;
				if (cnt_q == 8'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign res = q_q;
endmodule
`default_nettype wire

FILE: rtl/bond_force_accumulator.sv
// Bond force accumulator top level. Depends on bfa_pkg, bfa_ram, bfa_alu.
// Load: writes the point and clears its sums, no result. Read: fetches both sums, then a result strobe.
// Bond: busy through two 64-step square roots and three 128-step divides on the shared
// unit (the divides are skipped for a zero-length bond); result strobe follows.
// One item at a time; next item is taken at the edge ending the strobe cycle.
// Reset clears control and reaction_mode (to 1); stores undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module bond_force_accumulator #(
	parameter int unsigned POINTS = bfa_pkg::PointsDefault
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  op,
	input  wire logic [bfa_pkg::IdxW-1:0]    point_index,
	input  wire logic [bfa_pkg::IdxW-1:0]    neighbor_index,
	input  wire logic signed [31:0]          ref_x,
	input  wire logic signed [31:0]          ref_y,
	input  wire logic signed [31:0]          ref_z,
	input  wire logic signed [31:0]          def_x,
	input  wire logic signed [31:0]          def_y,
	input  wire logic signed [31:0]          def_z,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic                        cfg_data,
	output logic                             strobe,
	output logic                             kind,
	output logic signed [63:0]               force_x,
	output logic signed [63:0]               force_y,
	output logic signed [63:0]               force_z,
	output logic signed [63:0]               reaction_x,
	output logic signed [63:0]               reaction_y,
	output logic signed [63:0]               reaction_z,
	output logic                             zero_length,
	output logic                             saturated
);
	import bfa_pkg::*;

	localparam int unsigned PW = (POINTS > 1) ? $clog2(POINTS) : 1;
	localparam int unsigned DEPTH = POINTS * 4;
	localparam int unsigned AW = PW + 2;

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD, S_RDA, S_RDW, S_RDCAP, S_BRD, S_BRW, S_BCAP, S_SQ1, S_SQ1W,
		S_SQ2, S_SQ2W, S_TMUL, S_NML, S_NMH, S_DIV, S_DIVW, S_ACC_RD, S_ACC_W,
		S_ACC_WR, S_DONE
	} state_t;

	state_t          st_q;
	logic            mode_q;
	logic [1:0]      op_q;
	logic [PW-1:0]   p_q, n_q;
	logic [31:0]     in_ref_q [3];
	logic [31:0]     in_def_q [3];
	logic [1:0]      k_q;
	logic            side_q;
	logic signed [31:0] pr_q [3], pd_q [3];
	logic signed [32:0] dr_q [3], dd_q [3];
	logic [63:0]     zeta_q, dy_q;
	logic [67:0]     t_q;
	logic [127:0]    num_q;
	logic            eneg_q;
	logic signed [63:0] f_q [3];
	logic signed [63:0] fs_q [3], rs_q [3];
	logic            sat_q, zl_q;

	// coordinate RAM: word {point, k} holds ref in the upper half and def in the lower half
	logic            cwe, swe_f, swe_r;
	logic [AW-1:0]   caddr, saddr_f, saddr_r;
	logic [63:0]     cwdata, crdata;
	logic [63:0]     fwdata, frdata, rwdata, rrdata;

	bfa_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_coord (
		.clk(clk), .we(cwe), .addr(caddr), .wdata(cwdata), .rdata(crdata));
	bfa_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_force (
		.clk(clk), .we(swe_f), .addr(saddr_f), .wdata(fwdata), .rdata(frdata));
	bfa_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_react (
		.clk(clk), .we(swe_r), .addr(saddr_r), .wdata(rwdata), .rdata(rrdata));

	logic         alu_go, alu_sqrt, alu_done;
	logic [127:0] alu_num;
	logic [63:0]  alu_den, alu_res;

	bfa_alu u_alu (
		.clk(clk), .arst_n(arst_n), .go(alu_go), .is_sqrt(alu_sqrt),
		.num(alu_num), .den(alu_den), .done(alu_done), .res(alu_res));

	logic [PW-1:0] acc_pt;
	logic          acc_to_r;
	logic signed [63:0] acc_add, acc_old, acc_sum;
	logic          acc_ovf;
	logic [127:0]  sqsum_r, sqsum_d;
	logic [32:0]   md [3];
	logic [32:0]   mr [3];
	logic [63:0]   e_mag;
	logic [32:0]   ddm;
	logic [33:0]   nm_a;
	logic [66:0]   nm_prod;

	assign busy = (st_q != S_IDLE);
	assign cfg_ready = (st_q == S_IDLE) && !start;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mr[i] = dr_q[i][32] ? 33'(-dr_q[i]) : 33'(dr_q[i]);
			md[i] = dd_q[i][32] ? 33'(-dd_q[i]) : 33'(dd_q[i]);
		end
		sqsum_r = 128'(mr[0] * mr[0]) + 128'(mr[1] * mr[1]) + 128'(mr[2] * mr[2]);
		sqsum_d = 128'(md[0] * md[0]) + 128'(md[1] * md[1]) + 128'(md[2] * md[2]);
		e_mag = (dy_q >= zeta_q) ? (dy_q - zeta_q) : (zeta_q - dy_q);
		ddm = md[k_q];
		// split t into two 34-bit halves, one partial product per cycle
		nm_a = (st_q == S_NMH) ? t_q[67:34] : t_q[33:0];
		nm_prod = 67'(nm_a) * 67'(ddm);
	end

	always_comb begin
		acc_to_r = side_q && mode_q;
		acc_pt   = side_q ? n_q : p_q;
		acc_old  = acc_to_r ? signed'(rrdata) : signed'(frdata);
		acc_add  = side_q ? -f_q[k_q] : f_q[k_q];
		acc_sum  = acc_old + acc_add;
		acc_ovf  = (acc_old[63] == acc_add[63]) && (acc_sum[63] != acc_old[63]);
	end

	always_comb begin
		cwe = 1'b0; swe_f = 1'b0; swe_r = 1'b0;
		caddr = {p_q, k_q}; saddr_f = {p_q, k_q}; saddr_r = {p_q, k_q};
		cwdata = {in_ref_q[k_q], in_def_q[k_q]};
		fwdata = '0; rwdata = '0;
		alu_go = 1'b0; alu_sqrt = 1'b0; alu_num = '0; alu_den = '0;
		unique case (st_q)
			S_LOAD: begin
				cwe = 1'b1; swe_f = 1'b1; swe_r = 1'b1;
			end
			S_BRD, S_BRW: caddr = {side_q ? n_q : p_q, k_q};
			S_SQ1: begin
				alu_go = 1'b1; alu_sqrt = 1'b1; alu_num = sqsum_r;
			end
			S_SQ2: begin
				alu_go = 1'b1; alu_sqrt = 1'b1; alu_num = sqsum_d;
			end
			S_DIV: begin
				alu_go = 1'b1; alu_num = num_q; alu_den = {dy_q[43:0], 20'd0};
			end
			S_ACC_RD: begin
				saddr_f = {acc_pt, k_q}; saddr_r = {acc_pt, k_q};
			end
			S_ACC_W: begin
				saddr_f = {acc_pt, k_q}; saddr_r = {acc_pt, k_q};
			end
			S_ACC_WR: begin
				saddr_f = {acc_pt, k_q}; saddr_r = {acc_pt, k_q};
				swe_r = acc_to_r; swe_f = !acc_to_r;
				fwdata = acc_ovf ? (acc_add[63] ? 64'h8000_0000_0000_0000
					: 64'h7fff_ffff_ffff_ffff) : acc_sum;
				rwdata = fwdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			mode_q <= 1'b1;
			strobe <= 1'b0;
			k_q    <= '0;
			side_q <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						mode_q <= cfg_data;
					end
					if (start) begin
						op_q <= op;
						p_q <= PW'(point_index);
						n_q <= PW'(neighbor_index);
						in_ref_q[0] <= ref_x; in_ref_q[1] <= ref_y; in_ref_q[2] <= ref_z;
						in_def_q[0] <= def_x; in_def_q[1] <= def_y; in_def_q[2] <= def_z;
						k_q <= '0; side_q <= 1'b0; sat_q <= 1'b0; zl_q <= 1'b0;
						if (32'(point_index) >= POINTS) begin
							st_q <= S_IDLE;
						end else begin
							case (op)
								OP_LOAD: st_q <= S_LOAD;
								OP_READ: st_q <= S_RDA;
								OP_BOND: st_q <= (32'(neighbor_index) >= POINTS)
									? S_IDLE : S_BRD;
								default: st_q <= S_IDLE;
							endcase
						end
					end
				end
				S_LOAD: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd2) st_q <= S_IDLE;
				end
				S_RDA: st_q <= S_RDW;
				S_RDW: st_q <= S_RDCAP;
				S_RDCAP: begin
					fs_q[k_q] <= frdata; rs_q[k_q] <= rrdata;
					k_q <= k_q + 2'd1;
					st_q <= (k_q == 2'd2) ? S_DONE : S_RDA;
				end
				S_BRD: st_q <= S_BRW;
				S_BRW: st_q <= S_BCAP;
				S_BCAP: begin
					if (!side_q) begin
						pr_q[k_q] <= crdata[63:32]; pd_q[k_q] <= crdata[31:0];
					end else begin
						dr_q[k_q] <= 33'(signed'(crdata[63:32])) - 33'(pr_q[k_q]);
						dd_q[k_q] <= 33'(signed'(crdata[31:0])) - 33'(pd_q[k_q]);
					end
					if (k_q == 2'd2) begin
						k_q <= '0;
						side_q <= !side_q;
						st_q <= side_q ? S_SQ1 : S_BRD;
					end else begin
						k_q <= k_q + 2'd1;
						st_q <= S_BRD;
					end
				end
				S_SQ1: st_q <= S_SQ1W;
				S_SQ1W: if (alu_done) begin
					zeta_q <= alu_res; st_q <= S_SQ2;
				end
				S_SQ2: st_q <= S_SQ2W;
				S_SQ2W: if (alu_done) begin
					dy_q <= alu_res;
					if (alu_res == 64'd0) begin
						zl_q <= 1'b1;
						for (int i = 0; i < 3; i++) f_q[i] <= '0;
						st_q <= S_DONE;
					end else begin
						st_q <= S_TMUL;
					end
				end
				S_TMUL: begin
					t_q <= 68'(zeta_q[33:0]) * 68'(e_mag[33:0]);
					eneg_q <= (dy_q < zeta_q);
					k_q <= '0;
					st_q <= S_NML;
				end
				S_NML: begin
					num_q <= 128'(nm_prod);
					st_q <= S_NMH;
				end
				S_NMH: begin
					num_q <= num_q + {27'd0, nm_prod, 34'd0};
					st_q <= S_DIV;
				end
				S_DIV: st_q <= S_DIVW;
				S_DIVW: if (alu_done) begin
					f_q[k_q] <= (eneg_q != dd_q[k_q][32]) ? -alu_res : alu_res;
					if (k_q == 2'd2) begin
						k_q <= '0; side_q <= 1'b0; st_q <= S_ACC_RD;
					end else begin
						k_q <= k_q + 2'd1; st_q <= S_NML;
					end
				end
				S_ACC_RD: st_q <= S_ACC_W;
				S_ACC_W: st_q <= S_ACC_WR;
				S_ACC_WR: begin
					if (acc_ovf) sat_q <= 1'b1;
					if (side_q) begin
						side_q <= 1'b0;
						k_q <= k_q + 2'd1;
						st_q <= (k_q == 2'd2) ? S_DONE : S_ACC_RD;
					end else begin
						side_q <= 1'b1;
						st_q <= S_ACC_RD;
					end
				end
				S_DONE: begin
					strobe <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		if (op_q == OP_READ) begin
			kind = KIND_SUMS;
			force_x = fs_q[0]; force_y = fs_q[1]; force_z = fs_q[2];
			reaction_x = rs_q[0]; reaction_y = rs_q[1]; reaction_z = rs_q[2];
			zero_length = 1'b0; saturated = 1'b0;
		end else begin
			kind = KIND_BOND;
			force_x = f_q[0]; force_y = f_q[1]; force_z = f_q[2];
			reaction_x = '0; reaction_y = '0; reaction_z = '0;
			zero_length = zl_q; saturated = sat_q;
		end
	end

`ifndef SYNTHESIS
	a_strobe_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("result strobe held two cycles");
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy) else $error("strobe while busy");
	a_no_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cfg_ready) else $error("config ready while busy");
`endif
endmodule
`default_nettype wire

FILE: dv/bond_force_accumulator_tb.sv
// Testbench for bond_force_accumulator: directed then random load/bond/read items,
// predicted by a scoreboard class and checked field by field on each result strobe.
// Depends on rtl/bfa_pkg.sv and rtl/bond_force_accumulator.sv.
`timescale 1ns / 1ps

typedef struct {
	logic               kind;
	logic signed [63:0] frc [3];
	logic signed [63:0] rct [3];
	logic               zl;
	logic               sat;
} bond_result_t;

class bond_scoreboard;
	longint       ref_pos [4096*3];
	longint       def_pos [4096*3];
	longint       force_acc [4096*3];
	longint       react_acc [4096*3];
	bit           reaction_mode = 1'b1;
	bond_result_t pending [$];
	int           mismatches = 0;
	int           results_seen = 0;
	int           zero_bonds = 0;
	int           sat_bonds = 0;

	function automatic logic [33:0] floor_sqrt(logic [127:0] s);
		logic [127:0] r;
		logic [127:0] c;
		r = 0;
		for (int i = 33; i >= 0; i--) begin
			c = r | (128'd1 << i);
			if (c * c <= s)
				r = c;
		end
		return r[33:0];
	endfunction

	function automatic logic [33:0] length_of(longint d [3]);
		logic [127:0] s;
		logic [127:0] m;
		s = 0;
		for (int k = 0; k < 3; k++) begin
			m = (d[k] < 0) ? -d[k] : d[k];
			s += m * m;
		end
		return floor_sqrt(s);
	endfunction

	function automatic longint clip_add(longint a, longint b, inout bit flag);
		logic signed [64:0] s;
		s = 65'(signed'(a)) + 65'(signed'(b));
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
			flag = 1'b1;
			return 64'sh7FFF_FFFF_FFFF_FFFF;
		end
		if (s < -65'sh0_8000_0000_0000_0000) begin
			flag = 1'b1;
			return 64'sh8000_0000_0000_0000;
		end
		return s[63:0];
	endfunction

	// Note an accepted item and queue what it should produce.
	function automatic void note_item(bfa_pkg::op_t op, int p, int n, longint rc [3],
			longint dc [3]);
		bond_result_t res;
		longint dref [3];
		longint ddef [3];
		longint e;
		logic [33:0] zeta, dy;
		logic [127:0] t, num, q;
		logic [63:0] qlo;
		bit sat;
		res.kind = bfa_pkg::KIND_BOND;
		res.zl = 1'b0;
		res.sat = 1'b0;
		for (int k = 0; k < 3; k++) begin
			res.frc[k] = 0;
			res.rct[k] = 0;
		end
		case (op)
		bfa_pkg::OP_LOAD: begin
			for (int k = 0; k < 3; k++) begin
				ref_pos[p*3+k] = rc[k];
				def_pos[p*3+k] = dc[k];
				force_acc[p*3+k] = 0;
				react_acc[p*3+k] = 0;
			end
		end
		bfa_pkg::OP_READ: begin
			res.kind = bfa_pkg::KIND_SUMS;
			for (int k = 0; k < 3; k++) begin
				res.frc[k] = force_acc[p*3+k];
				res.rct[k] = react_acc[p*3+k];
			end
			pending.push_back(res);
		end
		bfa_pkg::OP_BOND: begin
			for (int k = 0; k < 3; k++) begin
				dref[k] = ref_pos[n*3+k] - ref_pos[p*3+k];
				ddef[k] = def_pos[n*3+k] - def_pos[p*3+k];
			end
			zeta = length_of(dref);
			dy = length_of(ddef);
			if (dy == 0) begin
				res.zl = 1'b1;
				zero_bonds++;
			end else begin
				sat = 1'b0;
				e = longint'(dy) - longint'(zeta);
				t = 128'(zeta) * 128'((e < 0) ? -e : e);
				for (int k = 0; k < 3; k++) begin
					num = t * 128'((ddef[k] < 0) ? -ddef[k] : ddef[k]);
					q = num / (128'(dy) << 20);
					qlo = q[63:0];
					res.frc[k] = ((e < 0) != (ddef[k] < 0)) ? -qlo : qlo;
				end
				for (int k = 0; k < 3; k++) begin
					force_acc[p*3+k] = clip_add(force_acc[p*3+k], res.frc[k], sat);
					if (!reaction_mode)
						force_acc[n*3+k] = clip_add(force_acc[n*3+k], -res.frc[k], sat);
					else
						react_acc[n*3+k] = clip_add(react_acc[n*3+k], -res.frc[k], sat);
				end
				res.sat = sat;
				if (sat)
					sat_bonds++;
			end
			pending.push_back(res);
		end
		default: ;
		endcase
	endfunction

	function automatic void check_result(bond_result_t got);
		bond_result_t exp_r;
		bit bad;
		results_seen++;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result with nothing expected, kind %0d", $realtime, got.kind);
			return;
		end
		exp_r = pending.pop_front();
		bad = (got.kind !== exp_r.kind) || (got.zl !== exp_r.zl) || (got.sat !== exp_r.sat);
		for (int k = 0; k < 3; k++)
			bad |= (got.frc[k] !== exp_r.frc[k]) || (got.rct[k] !== exp_r.rct[k]);
		if (bad) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: mismatch kind %0d/%0d zl %0d/%0d sat %0d/%0d (exp/got)",
					$realtime, exp_r.kind, got.kind, exp_r.zl, got.zl, exp_r.sat, got.sat);
				$display("  force exp %0d %0d %0d got %0d %0d %0d", exp_r.frc[0],
					exp_r.frc[1], exp_r.frc[2], got.frc[0], got.frc[1], got.frc[2]);
				$display("  react exp %0d %0d %0d got %0d %0d %0d", exp_r.rct[0],
					exp_r.rct[1], exp_r.rct[2], got.rct[0], got.rct[1], got.rct[2]);
			end
		end
	endfunction
endclass

module bond_force_accumulator_tb;
	import bfa_pkg::*;

	localparam int StallLimit = 20000;
	localparam int PoolSize = 24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] op = OP_NONE;
	logic [IdxW-1:0] point_index = '0;
	logic [IdxW-1:0] neighbor_index = '0;
	logic signed [31:0] ref_x = '0, ref_y = '0, ref_z = '0;
	logic signed [31:0] def_x = '0, def_y = '0, def_z = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic strobe, kind, zero_length, saturated;
	logic signed [63:0] force_x, force_y, force_z, reaction_x, reaction_y, reaction_z;

	bond_scoreboard sb = new();
	int idle_cycles = 0;
	int items_sent = 0;
	int pool [PoolSize];
	bit loaded [4096];

	bond_force_accumulator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.point_index(point_index), .neighbor_index(neighbor_index),
		.ref_x(ref_x), .ref_y(ref_y), .ref_z(ref_z),
		.def_x(def_x), .def_y(def_y), .def_z(def_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.strobe(strobe), .kind(kind), .force_x(force_x), .force_y(force_y),
		.force_z(force_z), .reaction_x(reaction_x), .reaction_y(reaction_y),
		.reaction_z(reaction_z), .zero_length(zero_length), .saturated(saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		bond_result_t got;
		if (strobe) begin
			got.kind = kind;
			got.frc[0] = force_x;
			got.frc[1] = force_y;
			got.frc[2] = force_z;
			got.rct[0] = reaction_x;
			got.rct[1] = reaction_y;
			got.rct[2] = reaction_z;
			got.zl = zero_length;
			got.sat = saturated;
			sb.check_result(got);
		end
	end

	// Watchdog: count cycles with neither an accepted item nor a result.
	always @(posedge clk) begin
		if (!arst_n || strobe || (start && !busy) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("timeout: no progress for %0d cycles", StallLimit);
			$display("bond_force_accumulator regression: fail");
			$finish;
		end
	end

	// Present one item and hold it until accepted; start stays high afterwards.
	task automatic send_item(op_t o, int p, int n, longint rc [3], longint dc [3]);
		longint rs [3];
		longint ds [3];
		op <= o;
		point_index <= p[IdxW-1:0];
		neighbor_index <= n[IdxW-1:0];
		ref_x <= rc[0][31:0];
		ref_y <= rc[1][31:0];
		ref_z <= rc[2][31:0];
		def_x <= dc[0][31:0];
		def_y <= dc[1][31:0];
		def_z <= dc[2][31:0];
		start <= 1'b1;
		do @(posedge clk); while (busy);
		for (int k = 0; k < 3; k++) begin
			rs[k] = longint'(signed'(rc[k][31:0]));
			ds[k] = longint'(signed'(dc[k][31:0]));
		end
		sb.note_item(o, p, n, rs, ds);
		if (o == OP_LOAD)
			loaded[p] = 1'b1;
		items_sent++;
	endtask

	task automatic gap(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Drain all results, then allow for a trailing load before touching the register.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0 || busy)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_mode(bit v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.reaction_mode = v;
	endtask

	function automatic longint rand_coord(int style);
		case (style)
		0: return longint'($urandom());
		1: return longint'($urandom_range(0, 131071)) - 65536;
		default: return longint'($urandom_range(0, 8388607)) - 4194304;
		endcase
	endfunction

	task automatic random_item(bit no_idle);
		longint rc [3];
		longint dc [3];
		int sel, p, n, style;
		op_t o;
		sel = $urandom_range(0, 99);
		p = pool[$urandom_range(0, PoolSize-1)];
		n = pool[$urandom_range(0, PoolSize-1)];
		style = $urandom_range(0, 2);
		for (int k = 0; k < 3; k++) begin
			rc[k] = rand_coord(style);
			dc[k] = ($urandom_range(0, 9) == 0) ? rc[k] : rand_coord(style);
		end
		if (sel < 12 || !loaded[p])
			o = OP_LOAD;
		else if (sel < 65)
			o = OP_BOND;
		else if (sel < 93)
			o = OP_READ;
		else
			o = OP_NONE;
		if (o == OP_BOND && !loaded[n])
			n = p;
		// occasionally copy a neighbour's deformed position to hit zero length
		if (o == OP_LOAD && loaded[n] && $urandom_range(0, 7) == 0)
			for (int k = 0; k < 3; k++)
				dc[k] = sb.def_pos[n*3+k];
		send_item(o, p, n, rc, dc);
		if (!no_idle && $urandom_range(0, 99) < 34)
			gap($urandom_range(1, 6));
	endtask

	initial begin
		longint lo [3] = '{-64'sd2147483648, -64'sd2147483648, -64'sd2147483648};
		longint hi [3] = '{64'sd2147483647, 64'sd2147483647, 64'sd2147483647};
		longint sm [3] = '{64'sd1048576, -64'sd3, 64'sd0};
		longint nul [3] = '{0, 0, 0};
		pool[0] = 0;
		pool[1] = 4095;
		for (int i = 2; i < PoolSize; i++)
			pool[i] = $urandom_range(1, 4094);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every op, zero length, self bond, unused op
		send_item(OP_LOAD, 0, 0, lo, lo);
		send_item(OP_LOAD, 4095, 0, hi, hi);
		send_item(OP_LOAD, pool[2], 0, sm, lo);
		send_item(OP_LOAD, pool[3], 0, nul, sm);
		send_item(OP_BOND, 0, 4095, nul, nul);
		send_item(OP_BOND, 4095, 0, nul, nul);
		send_item(OP_BOND, 0, 0, nul, nul);
		send_item(OP_BOND, 0, pool[2], nul, nul);
		send_item(OP_BOND, pool[3], 4095, nul, nul);
		send_item(OP_BOND, pool[2], pool[3], nul, nul);
		send_item(OP_NONE, 4095, 4095, hi, hi);
		send_item(OP_READ, 0, 0, nul, nul);
		send_item(OP_READ, 4095, 0, nul, nul);
		send_item(OP_READ, pool[2], 0, nul, nul);
		send_item(OP_READ, pool[3], 0, nul, nul);
		drain();

		write_mode(1'b0);
		send_item(OP_BOND, 0, 4095, nul, nul);
		send_item(OP_BOND, pool[3], pool[2], nul, nul);
		send_item(OP_READ, 4095, 0, nul, nul);
		send_item(OP_READ, pool[2], 0, nul, nul);
		gap(3);

		for (int i = 0; i < 400; i++)
			random_item(1'b0);
		drain();
		write_mode(1'b1);
		for (int i = 0; i < 300; i++)
			random_item(1'b1);
		drain();
		write_mode(1'b0);
		for (int i = 0; i < 300; i++)
			random_item(1'b0);
		drain();
		write_mode(1'b1);
		for (int i = 0; i < 230; i++)
			random_item(1'b0);
		drain();
		repeat (700) @(posedge clk);

		$display("covered %0d items, %0d results (%0d zero-length bonds, %0d saturating)",
			items_sent, sb.results_seen, sb.zero_bonds, sb.sat_bonds);
		$display("both reaction modes exercised; %0d mismatches, %0d results left over",
			sb.mismatches, sb.pending.size());
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("bond_force_accumulator regression: pass");
		else
			$display("bond_force_accumulator regression: fail");
		$finish;
	end
endmodule
